// ===== sv/blc_pkg.sv =====
// shared types and constants for the led blink code controller
// no dependencies
package blc_pkg;

  localparam int unsigned DurW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DurW-1:0]   PhaseMax = 16'hFFFF;
  localparam logic [CountW-1:0] CountMax = 8'hFF;
  localparam logic [CountW-1:0] TaskMin  = 8'd2;
  localparam logic [CountW-1:0] TaskMax  = 8'd6;

  localparam logic [DurW-1:0] CodeOnRst    = 16'd200;
  localparam logic [DurW-1:0] CodeOffRst   = 16'd400;
  localparam logic [DurW-1:0] FinishRst    = 16'd500;
  localparam logic [DurW-1:0] FaultRst     = 16'd100;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_RUNNING  = 3'd1,
    MODE_CODE     = 3'd2,
    MODE_FINISHED = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_SHOW     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CODE_ON  = 2'd0,
    CFG_CODE_OFF = 2'd1,
    CFG_FINISHED = 2'd2,
    CFG_FAULT    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DurW-1:0] code_on_ms;
    logic [DurW-1:0] code_off_ms;
    logic [DurW-1:0] finished_toggle_ms;
    logic [DurW-1:0] fault_toggle_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        restore_mode;
    logic [CountW-1:0] task_number;
    logic [2:0]        mode_request;
    logic [1:0]        op;
  } item_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       led_on;
  } res_t;

endpackage

// ===== sv/blc_cfg_regs.sv =====
// configuration register bank for the led blink code controller
// depends on blc_pkg
module blc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [blc_pkg::DurW-1:0]      cfg_data_i,
  output blc_pkg::cfg_t                 cfg_o
);
  import blc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CODE_ON:  cfg_d.code_on_ms         = cfg_data_i;
        CFG_CODE_OFF: cfg_d.code_off_ms        = cfg_data_i;
        CFG_FINISHED: cfg_d.finished_toggle_ms = cfg_data_i;
        CFG_FAULT:    cfg_d.fault_toggle_ms    = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_on_ms         <= CodeOnRst;
      cfg_q.code_off_ms        <= CodeOffRst;
      cfg_q.finished_toggle_ms <= FinishRst;
      cfg_q.fault_toggle_ms    <= FaultRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/blc_core.sv =====
// mode and phase state with single-pass next-state logic
// depends on blc_pkg
module blc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_fire_i,
  input  blc_pkg::item_t item_i,
  input  blc_pkg::cfg_t  cfg_i,
  output blc_pkg::res_t  next_o,
  output blc_pkg::res_t  cur_o
);
  import blc_pkg::*;

  mode_e             mode_q, mode_d;
  mode_e             restore_q, restore_d;
  logic [CountW-1:0] target_q, target_d;
  logic [CountW-1:0] done_q, done_d;
  logic              on_q, on_d;
  logic [DurW-1:0]   phase_q, phase_d;
  logic              led_q, led_d;

  logic [DurW-1:0]   phase_inc;
  logic [CountW-1:0] done_inc;
  logic [DurW-1:0]   interval;
  mode_e             req_mode;
  mode_e             rest_mode;

  assign phase_inc = (phase_q == PhaseMax) ? phase_q : phase_q + 16'd1;
  assign done_inc  = (done_q == CountMax) ? done_q : done_q + 8'd1;
  assign req_mode  = (item_i.mode_request > 3'(MODE_FAULT)) ? MODE_FAULT
                                                             : mode_e'(item_i.mode_request);
  assign rest_mode = (item_i.restore_mode > 3'(MODE_FAULT) ||
                      item_i.restore_mode == 3'(MODE_CODE)) ? MODE_OFF
                                                            : mode_e'(item_i.restore_mode);

  always_comb begin
    unique case (mode_q)
      MODE_CODE:     interval = on_q ? cfg_i.code_on_ms : cfg_i.code_off_ms;
      MODE_FINISHED: interval = cfg_i.finished_toggle_ms;
      default:       interval = cfg_i.fault_toggle_ms;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    restore_d = restore_q;
    target_d  = target_q;
    done_d    = done_q;
    on_d      = on_q;
    phase_d   = phase_q;
    led_d     = led_q;
    unique case (op_e'(item_i.op))
      OP_TICK: begin
        unique case (mode_q)
          MODE_CODE: begin
            if (phase_inc < interval) begin
              phase_d = phase_inc;
            end else begin
              phase_d = '0;
              if (on_q) begin
                on_d   = 1'b0;
                led_d  = 1'b0;
                done_d = done_inc;
                if (done_inc >= target_q) begin
                  // code finished, start the restore mode
                  mode_d = restore_q;
                  on_d   = (restore_q == MODE_FINISHED) || (restore_q == MODE_FAULT);
                  led_d  = (restore_q != MODE_OFF) && (restore_q != MODE_CODE);
                end
              end else begin
                on_d  = 1'b1;
                led_d = 1'b1;
              end
            end
          end
          MODE_FINISHED, MODE_FAULT: begin
            if (phase_inc >= interval) begin
              phase_d = '0;
              on_d    = ~on_q;
              led_d   = ~on_q;
            end else begin
              phase_d = phase_inc;
            end
          end
          default: begin
          end
        endcase
      end
      OP_SET_MODE: begin
        target_d  = '0;
        done_d    = '0;
        restore_d = MODE_OFF;
        mode_d    = req_mode;
        phase_d   = '0;
        on_d      = (req_mode == MODE_FINISHED) || (req_mode == MODE_FAULT);
        led_d     = (req_mode != MODE_OFF) && (req_mode != MODE_CODE);
      end
      OP_SHOW: begin
        phase_d = '0;
        done_d  = '0;
        on_d    = 1'b1;
        led_d   = 1'b1;
        if (item_i.task_number < TaskMin || item_i.task_number > TaskMax) begin
          // bad task number acts as set mode fault
          target_d  = '0;
          restore_d = MODE_OFF;
          mode_d    = MODE_FAULT;
        end else begin
          target_d  = item_i.task_number;
          restore_d = rest_mode;
          mode_d    = MODE_CODE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      restore_q <= MODE_OFF;
      target_q  <= '0;
      done_q    <= '0;
      on_q      <= 1'b0;
      phase_q   <= '0;
      led_q     <= 1'b0;
    end else if (item_fire_i) begin
      mode_q    <= mode_d;
      restore_q <= restore_d;
      target_q  <= target_d;
      done_q    <= done_d;
      on_q      <= on_d;
      phase_q   <= phase_d;
      led_q     <= led_d;
    end
  end

  assign next_o.mode_now = mode_d;
  assign next_o.led_on   = led_d;
  assign cur_o.mode_now  = mode_q;
  assign cur_o.led_on    = led_q;

endmodule

// ===== sv/blc_out_reg.sv =====
// result register between the update logic and the output stream
// depends on blc_pkg
module blc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  blc_pkg::res_t res_i,
  input  logic          take_i,
  output logic          free_o,
  output logic          valid_o,
  output blc_pkg::res_t res_o
);
  import blc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/led_blink_code_controller_core.sv =====
// led blink code controller, top level
// depends on blc_pkg, blc_cfg_regs, blc_core, blc_out_reg
//
// usage:
//   s_axis carries one command per transfer: a 1 ms tick, a set-mode request
//   or a show-task request. m_axis returns one result per command: the led
//   level and the mode after that command.
//   cfg_we_i / cfg_idx_i / cfg_data_i write the four duration registers
//   (code on, code off, finished toggle, fault toggle); write only when idle.
// timing:
//   one command per cycle while m_axis takes results; the result is on m_axis
//   in the cycle after its transfer. the update of the small counters is one
//   pass of logic between the state registers, so throughput is one item per clock.
// reset:
//   mode off, led dark, counters cleared, durations 200/400/500/100 ms,
//   no result pending.
// stall:
//   a single result register holds the pending result; s_axis_tready is
//   high while it is empty or being taken, so a stalled receiver stops
//   input after one result without losing anything.
module led_blink_code_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // op[1:0], mode_request[4:2], task_number[12:5], restore_mode[15:13]
  input  logic [15:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // led_on[0], mode_now[3:1], zero fill[7:4]
  output logic [7:0]                  m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [blc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [blc_pkg::DurW-1:0]    cfg_data_i
);
  import blc_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  next_res;
  res_t  cur_res;
  res_t  out_res;
  logic  in_fire;
  logic  free;

  assign item    = item_t'(s_axis_tdata);
  assign in_fire = s_axis_tvalid && free;
  assign s_axis_tready = free;

  blc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_fire_i (in_fire),
    .item_i      (item),
    .cfg_i       (cfg),
    .next_o      (next_res),
    .cur_o       (cur_res)
  );

  blc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .res_i   (next_res),
    .take_i  (m_axis_tready),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.mode_now, out_res.led_on};

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted command produced no result");

  a_result_is_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_res == cur_res))
    else $error("result differs from updated state");

  a_running_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_res.mode_now == MODE_RUNNING) |-> cur_res.led_on)
    else $error("running mode with led dark");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_res.mode_now == MODE_OFF) |-> !cur_res.led_on)
    else $error("off mode with led lit");
`endif

endmodule
